// File: rtl/rost_pkg.sv
package rost_pkg;

  localparam int POS_W   = 20;
  localparam int VEC_W   = 16;
  localparam int DELTA_W = 21;
  localparam int PE_W    = 37;
  localparam int PF_W    = 32;
  localparam int E_W     = 39;
  localparam int F_W     = 34;
  localparam int N_W     = 40;
  localparam int FRAC_SH = 14;
  localparam int NUM_W   = 54;
  localparam int DEN_W   = 34;
  localparam int Q_W     = 20;
  localparam int T_W     = 22;
  localparam int DIV_LAT = Q_W + 1;
  localparam int QDEPTH  = 8;
  localparam int QAW     = 3;
  localparam int CLIP_W  = 20;

  // 0.001 in Q.28
  localparam logic [F_W-1:0] PAR_EPS = 34'd268435;

  localparam logic [CLIP_W-1:0] NEAR_RST = 20'd26;
  localparam logic [CLIP_W-1:0] FAR_RST  = 20'd256000;

  // register index decoded from paddr[2]
  localparam logic REG_NEAR = 1'b0;
  localparam logic REG_FAR  = 1'b1;

  typedef struct packed {
    logic [59:0] ray_origin;
    logic [47:0] ray_dir;
    logic [59:0] box_center;
    logic [47:0] box_axis_x;
    logic [47:0] box_axis_y;
    logic [47:0] box_axis_z;
    logic [59:0] box_min;
    logic [59:0] box_max;
  } rost_in_t;

  typedef struct packed {
    logic        hit;
    logic [19:0] hit_distance;
  } rost_out_t;

  // per-axis projections handed from front to back
  typedef struct packed {
    logic [2:0][E_W-1:0]   e;
    logic [2:0][F_W-1:0]   f;
    logic [2:0][POS_W-1:0] mn;
    logic [2:0][POS_W-1:0] mx;
  } slab_t;

  typedef struct packed {
    logic [2:0] par;
    logic [2:0] par_ok;
  } slab_flags_t;

  typedef struct packed {
    logic             sat;
    logic             neg;
    logic [DEN_W-1:0] r;
    logic [Q_W-1:0]   low;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   q;
  } div_stage_t;

endpackage

// File: rtl/rost_fifo.sv
module rost_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  rost_pkg::slab_t       push_data,
  input  logic                  pop,
  output rost_pkg::slab_t       pop_data,
  output logic [rost_pkg::QAW:0] count,
  output logic                  empty
);

  localparam int AW = rost_pkg::QAW;

  rost_pkg::slab_t mem [rost_pkg::QDEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;

  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/rost_front.sv
module rost_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  rost_pkg::rost_in_t      in_data,
  input  logic [rost_pkg::QAW:0]  q_count,
  output logic                    push,
  output rost_pkg::slab_t         push_data
);

  localparam int PW = rost_pkg::POS_W;
  localparam int VW = rost_pkg::VEC_W;
  localparam int DW = rost_pkg::DELTA_W;
  localparam int EW = rost_pkg::E_W;
  localparam int FW = rost_pkg::F_W;
  localparam int OW = rost_pkg::QAW + 2;

  logic v0, v1, v2, v3;
  logic accept;
  logic [OW-1:0] occ;

  rost_pkg::rost_in_t s0;

  logic signed [DW-1:0] d1 [3];
  logic signed [VW-1:0] dir1 [3];
  logic signed [VW-1:0] ax1 [3][3];
  logic [PW-1:0] mn1 [3], mx1 [3];

  logic signed [rost_pkg::PE_W-1:0] pe [3][3];
  logic signed [rost_pkg::PF_W-1:0] pf [3][3];
  logic [PW-1:0] mn2 [3], mx2 [3];

  logic signed [EW-1:0] e3 [3];
  logic signed [FW-1:0] f3 [3];
  logic [PW-1:0] mn3 [3], mx3 [3];

  // four front stages plus queue fill must leave room
  assign occ = OW'(q_count) + OW'(v0) + OW'(v1) + OW'(v2) + OW'(v3);
  assign in_stall = (occ >= OW'(rost_pkg::QDEPTH));
  assign accept = in_valid && !in_stall;
  assign push = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v0 <= accept;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0 <= in_data;
    end
  end

  // offset box center to ray origin, unpack vectors
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      d1[k]     <= DW'($signed(s0.box_center[k*PW +: PW]))
                 - DW'($signed(s0.ray_origin[k*PW +: PW]));
      dir1[k]   <= $signed(s0.ray_dir[k*VW +: VW]);
      ax1[0][k] <= $signed(s0.box_axis_x[k*VW +: VW]);
      ax1[1][k] <= $signed(s0.box_axis_y[k*VW +: VW]);
      ax1[2][k] <= $signed(s0.box_axis_z[k*VW +: VW]);
      mn1[k]    <= s0.box_min[k*PW +: PW];
      mx1[k]    <= s0.box_max[k*PW +: PW];
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      for (int c = 0; c < 3; c++) begin
        pe[a][c] <= ax1[a][c] * d1[c];
        pf[a][c] <= dir1[c] * ax1[a][c];
      end
      mn2[a] <= mn1[a];
      mx2[a] <= mx1[a];
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      e3[a]  <= EW'(pe[a][0]) + EW'(pe[a][1]) + EW'(pe[a][2]);
      f3[a]  <= FW'(pf[a][0]) + FW'(pf[a][1]) + FW'(pf[a][2]);
      mn3[a] <= mn2[a];
      mx3[a] <= mx2[a];
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      push_data.e[a]  = e3[a];
      push_data.f[a]  = f3[a];
      push_data.mn[a] = mn3[a];
      push_data.mx[a] = mx3[a];
    end
  end

endmodule

// File: rtl/rost_div.sv
module rost_div (
  input  logic                               clk,
  input  logic                               en,
  input  logic [rost_pkg::NUM_W-1:0]         num,
  input  logic [rost_pkg::DEN_W-1:0]         den,
  input  logic                               neg,
  output logic signed [rost_pkg::T_W-1:0]    t
);

  localparam int QW = rost_pkg::Q_W;
  localparam int DN = rost_pkg::DEN_W;
  localparam int NW = rost_pkg::NUM_W;
  localparam int TW = rost_pkg::T_W;

  rost_pkg::div_stage_t s   [rost_pkg::DIV_LAT];
  rost_pkg::div_stage_t nxt [rost_pkg::DIV_LAT];

  // one quotient bit per stage, restoring
  always_comb begin
    logic [DN:0] trial;
    nxt[0]     = s[0];
    nxt[0].sat = (num[NW-1:QW] >= den);
    nxt[0].neg = neg;
    nxt[0].r   = num[NW-1:QW];
    nxt[0].low = num[QW-1:0];
    nxt[0].den = den;
    nxt[0].q   = '0;
    for (int k = 1; k < rost_pkg::DIV_LAT; k++) begin
      trial      = {s[k-1].r, s[k-1].low[QW-1]};
      nxt[k]     = s[k-1];
      nxt[k].low = {s[k-1].low[QW-2:0], 1'b0};
      if (trial >= {1'b0, s[k-1].den}) begin
        nxt[k].r = DN'(trial - {1'b0, s[k-1].den});
        nxt[k].q = {s[k-1].q[QW-2:0], 1'b1};
      end else begin
        nxt[k].r = trial[DN-1:0];
        nxt[k].q = {s[k-1].q[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < rost_pkg::DIV_LAT; k++) begin
        s[k] <= nxt[k];
      end
    end
  end

  // clamp to [-1, 2^Q_W]: monotone, so slab compares are unchanged
  always_comb begin
    if (s[QW].sat) begin
      t = s[QW].neg ? -TW'(1) : TW'(1) <<< QW;
    end else if (s[QW].neg) begin
      t = (s[QW].q == '0) ? '0 : -TW'(1);
    end else begin
      t = $signed({2'b00, s[QW].q});
    end
  end

endmodule

// File: rtl/rost_back.sv
module rost_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_empty,
  output logic                                 pop,
  input  rost_pkg::slab_t                      q_data,
  input  logic [rost_pkg::CLIP_W-1:0]          near_clip,
  input  logic [rost_pkg::CLIP_W-1:0]          far_clip,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output rost_pkg::rost_out_t                  out_data
);

  localparam int NW  = rost_pkg::N_W;
  localparam int FW  = rost_pkg::F_W;
  localparam int TW  = rost_pkg::T_W;
  localparam int SH  = rost_pkg::FRAC_SH;
  localparam int NUM = rost_pkg::NUM_W;
  localparam int LAT = rost_pkg::DIV_LAT;

  logic adv;

  logic signed [NW-1:0] ec [3], loc [3], hic [3], n1c [3], n2c [3];
  logic signed [FW-1:0] fc [3];
  logic [NW-1:0] a1c [3], a2c [3];
  logic [FW-1:0] fa [3];
  rost_pkg::slab_flags_t flg_c;

  logic vb0;
  logic [NUM-1:0] num1 [3], num2 [3];
  logic [FW-1:0]  den  [3];
  logic neg1 [3], neg2 [3];
  rost_pkg::slab_flags_t flg0;

  logic                  vd  [LAT];
  rost_pkg::slab_flags_t tag [LAT];

  logic signed [TW-1:0] td1 [3], td2 [3];

  logic vr1;
  logic signed [TW-1:0] lo_t [3], hi_t [3];
  rost_pkg::slab_flags_t flg1;

  logic signed [TW-1:0] tmn, tmx;
  logic hit_c;

  assign adv = !out_valid || !out_stall;
  assign pop = adv && !q_empty;

  // numerators, magnitudes, parallel test
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ec[a]  = NW'($signed(q_data.e[a]));
      loc[a] = NW'($signed({q_data.mn[a], {SH{1'b0}}}));
      hic[a] = NW'($signed({q_data.mx[a], {SH{1'b0}}}));
      fc[a]  = $signed(q_data.f[a]);
      n1c[a] = ec[a] + loc[a];
      n2c[a] = ec[a] + hic[a];
      a1c[a] = n1c[a][NW-1] ? NW'(-n1c[a]) : NW'(n1c[a]);
      a2c[a] = n2c[a][NW-1] ? NW'(-n2c[a]) : NW'(n2c[a]);
      fa[a]  = fc[a][FW-1] ? FW'(-fc[a]) : FW'(fc[a]);
      flg_c.par[a]    = !(fa[a] > rost_pkg::PAR_EPS);
      flg_c.par_ok[a] = (ec[a] >= loc[a]) && (ec[a] <= hic[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        num1[a] <= {a1c[a], {SH{1'b0}}};
        num2[a] <= {a2c[a], {SH{1'b0}}};
        den[a]  <= fa[a];
        neg1[a] <= n1c[a][NW-1] ^ fc[a][FW-1];
        neg2[a] <= n2c[a][NW-1] ^ fc[a][FW-1];
      end
      flg0 <= flg_c;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_div
    rost_div u_div1 (
      .clk (clk), .en (adv), .num (num1[a]), .den (den[a]), .neg (neg1[a]), .t (td1[a])
    );
    rost_div u_div2 (
      .clk (clk), .en (adv), .num (num2[a]), .den (den[a]), .neg (neg2[a]), .t (td2[a])
    );
  end

  // flags ride alongside the divider stages
  always_ff @(posedge clk) begin
    if (adv) begin
      tag[0] <= flg0;
      for (int k = 1; k < LAT; k++) begin
        tag[k] <= tag[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        if (td1[a] > td2[a]) begin
          lo_t[a] <= td2[a];
          hi_t[a] <= td1[a];
        end else begin
          lo_t[a] <= td1[a];
          hi_t[a] <= td2[a];
        end
      end
      flg1 <= tag[LAT-1];
    end
  end

  always_comb begin
    tmn   = $signed({2'b00, near_clip});
    tmx   = $signed({2'b00, far_clip});
    hit_c = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (flg1.par[a]) begin
        hit_c = hit_c && flg1.par_ok[a];
      end else begin
        if (hi_t[a] < tmx) begin
          tmx = hi_t[a];
        end
        if (lo_t[a] > tmn) begin
          tmn = lo_t[a];
        end
      end
    end
    hit_c = hit_c && !(tmx < tmn);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.hit          <= hit_c;
      out_data.hit_distance <= hit_c ? tmn[rost_pkg::CLIP_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb0       <= 1'b0;
      vr1       <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k < LAT; k++) begin
        vd[k] <= 1'b0;
      end
    end else if (adv) begin
      vb0   <= pop;
      vd[0] <= vb0;
      for (int k = 1; k < LAT; k++) begin
        vd[k] <= vd[k-1];
      end
      vr1       <= vd[LAT-1];
      out_valid <= vr1;
    end
  end

endmodule

// File: rtl/ray_obb_slab_test_top.sv
// Channel   | Valid      | Stall      | Payload            | Moves
// ----------+------------+------------+--------------------+---------------------------
// ray in    | ray_valid  | ray_stall  | ray  (rost_in_t)   | one ray/box request
// result    | res_valid  | res_stall  | res  (rost_out_t)  | hit flag + entry distance
// config    | APB psel/penable/pwrite, paddr[2] picks near_clip (0) or far_clip (4)
//
// Throughput: one request per cycle while ray_stall and res_stall stay low. Six pipelined
// restoring dividers (one quotient bit per stage) sit on the path: 4 front stages, queue,
// 1 setup stage, 21 divider stages, 1 ordering stage and the result register.
// Reset: synchronous, active high; clears queue, valid bits, near_clip = 26, far_clip = 256000.
// res_stall freezes the whole back pipeline while res_valid is high; requests keep entering
// until the queue and the front stages together hold 8 requests, then ray_stall rises.
module ray_obb_slab_test_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                ray_valid,
  output logic                ray_stall,
  input  rost_pkg::rost_in_t  ray,
  output logic                res_valid,
  input  logic                res_stall,
  output rost_pkg::rost_out_t res
);

  localparam int CW = rost_pkg::CLIP_W;

  logic [CW-1:0] near_clip;
  logic [CW-1:0] far_clip;

  logic                  push;
  rost_pkg::slab_t       push_data;
  logic                  pop;
  rost_pkg::slab_t       pop_data;
  logic [rost_pkg::QAW:0] q_count;
  logic                  q_empty;

  // config registers; the user must write them only while idle, the block does not enforce it
  assign pready = 1'b1;
  assign prdata = (paddr[2] == rost_pkg::REG_FAR) ? {{(32-CW){1'b0}}, far_clip}
                                                  : {{(32-CW){1'b0}}, near_clip};

  always_ff @(posedge clk) begin
    if (rst) begin
      near_clip <= rost_pkg::NEAR_RST;
      far_clip  <= rost_pkg::FAR_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == rost_pkg::REG_NEAR) begin
        near_clip <= pwdata[CW-1:0];
      end else begin
        far_clip <= pwdata[CW-1:0];
      end
    end
  end

  // front: delta, dot products, projection sums
  rost_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ray_valid),
    .in_stall  (ray_stall),
    .in_data   (ray),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  rost_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .count     (q_count),
    .empty     (q_empty)
  );

  // back: slab divisions and interval clipping
  rost_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .pop       (pop),
    .q_data    (pop_data),
    .near_clip (near_clip),
    .far_clip  (far_clip),
    .out_valid (res_valid),
    .out_stall (res_stall),
    .out_data  (res)
  );

endmodule
